@@ design/sbg_pkg.sv @@
// Shared types, constants and the crush function for the stutter/bitcrush glitch block.
package sbg_pkg;

   localparam int MaxCapture = 16384;
   localparam int MaxBlock   = 4096;
   localparam int SampleBits = 16;

   localparam logic [1:0] CSR_SPM     = 2'd0;
   localparam logic [1:0] CSR_MIN_GAP = 2'd1;
   localparam logic [1:0] CSR_MAX_CAP = 2'd2;

   typedef struct packed {
      logic signed [15:0] sample_in;
      logic               block_start;
      logic [12:0]        block_length;
      logic [9:0]         amount;
      logic [15:0]        rand_trigger;
      logic [15:0]        rand_length;
      logic [2:0]         rand_repeats;
   } req_type;

   typedef struct packed {
      logic signed [15:0] sample_out;
      logic               stutter_active;
   } rsp_type;

   // Classified item handed from front to back.
   typedef struct packed {
      logic signed [15:0] sample;
      logic               start;
      logic [12:0]        len;
      logic [9:0]         amount;
      logic [15:0]        rand_trigger;
      logic [15:0]        rand_length;
      logic [2:0]         rep;
   } item_type;

   // Rounds half away from zero to the bit depth chosen by amount.
   function automatic logic signed [15:0] crush(input logic signed [15:0] s,
                                                 input logic [9:0] amt);
      logic [15:0] bits;
      logic [4:0]  k;
      logic [16:0] mag;
      logic [16:0] half;
      logic [16:0] q;
      logic [17:0] r;
      bits = 16'd3 + 16'((17'd30 * (17'd1024 - {7'd0, amt})) >> 10);
      if (bits >= 16'(SampleBits)) begin
         crush = s;
      end else begin
         k    = 5'(16'(SampleBits) - bits);
         mag  = s[15] ? 17'(-{s[15], s}) : {1'b0, s};
         half = 17'd1 << (k - 5'd1);
         q    = ((mag + half) >> k) << k;
         if (s[15]) begin
            r = -{1'b0, q};
            crush = r[15:0];
         end else if (q > 17'd32767) begin
            crush = 16'sd32767;
         end else begin
            crush = q[15:0];
         end
      end
   endfunction

endpackage

@@ design/sbg_front.sv @@
// Front end: accepts requests, clamps fields and queues them for the back end.
module sbg_front import sbg_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   output logic     req_ready,
   input  req_type  req_data,
   output logic     q_valid,
   input  logic     q_ready,
   output item_type q_item
);
   item_type    mem_ff [2];
   logic [1:0]  cnt_ff, cnt_in;
   logic        wp_ff, rp_ff;
   item_type    it;
   logic        push, pop;

   always_comb begin
      it.sample       = req_data.sample_in;
      it.start        = req_data.block_start;
      it.amount       = req_data.amount;
      it.rand_trigger = req_data.rand_trigger;
      it.rand_length  = req_data.rand_length;
      it.rep          = (req_data.rand_repeats > 3'd4) ? 3'd4 : req_data.rand_repeats;
      if (req_data.block_length == 13'd0) it.len = 13'd1;
      else if (req_data.block_length > 13'(MaxBlock)) it.len = 13'(MaxBlock);
      else it.len = req_data.block_length;
   end

   assign req_ready = (cnt_ff != 2'd2);
   assign push      = req_valid && req_ready;
   assign q_valid   = (cnt_ff != 2'd0);
   assign pop       = q_valid && q_ready;
   assign q_item    = mem_ff[rp_ff];
   assign cnt_in    = cnt_ff + {1'b0, push} - {1'b0, pop};

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
         wp_ff  <= 1'b0;
         rp_ff  <= 1'b0;
      end else begin
         cnt_ff <= cnt_in;
         if (push) wp_ff <= ~wp_ff;
         if (pop) rp_ff <= ~rp_ff;
      end
      if (push) mem_ff[wp_ff] <= it;
   end
endmodule

@@ design/sbg_back.sv @@
// Back end: bitcrush, trigger test, capture store and replay.
module sbg_back import sbg_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        q_valid,
   output logic        q_ready,
   input  item_type    q_item,
   input  logic [15:0] spm_q8,
   input  logic [23:0] min_gap,
   input  logic [14:0] max_cap,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output rsp_type     rsp_data
);
   typedef enum logic [2:0] {S_IDLE, S_MUL1, S_MUL2, S_MEM, S_OUT} state_type;

   state_type   state_ff;
   item_type    it_ff;
   logic        running_ff;
   logic [13:0] ccount_ff;  // captured count (up to 4096)
   logic [13:0] climit_ff;
   logic [14:0] clen_ff;
   logic [16:0] remain_ff;
   logic [13:0] rindex_ff;
   logic [23:0] gap_ff;
   logic [9:0]  held_ff;
   logic [11:0] bidx_ff;
   logic [36:0] num_ff;
   logic [52:0] prod_ff;
   logic        trig_ff;
   logic signed [15:0] x_ff;
   logic        act_ff;
   logic        rvalid_ff;
   rsp_type     rsp_ff;
   logic signed [15:0] mem [MaxCapture];
   logic signed [15:0] rd_ff;
   logic        use_mem_ff;

   logic [24:0] gsum;
   logic [14:0] hi;
   logic [52:0] cl;
   logic [14:0] cl15;
   logic [13:0] len14;

   assign q_ready  = (state_ff == S_IDLE);
   assign rsp_valid = rvalid_ff;
   assign rsp_data  = rsp_ff;
   assign len14     = {1'b0, it_ff.len};
   assign gsum      = {1'b0, gap_ff} + 25'(q_item.len);
   assign hi = (max_cap > 15'(MaxCapture)) ? 15'(MaxCapture) :
               (max_cap < 15'd64) ? 15'd64 : max_cap;
   assign cl = prod_ff >> 34;
   assign cl15 = (cl < 53'd64) ? 15'd64 : (cl > {38'd0, hi}) ? hi : cl[14:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         running_ff <= 1'b0;
         ccount_ff  <= '0;
         climit_ff  <= '0;
         clen_ff    <= '0;
         remain_ff  <= '0;
         rindex_ff  <= '0;
         gap_ff     <= '0;
         held_ff    <= '0;
         bidx_ff    <= '0;
         rvalid_ff  <= 1'b0;
      end else begin
         if (rvalid_ff && rsp_ready && state_ff != S_OUT) rvalid_ff <= 1'b0;
         case (state_ff)
            S_IDLE: begin
               if (q_valid && q_ready) begin
                  it_ff <= q_item;
                  // Block start: latch amount, close capture; when amount exceeds 1, update gap and test trigger.
                  if (q_item.start) begin
                     held_ff   <= q_item.amount;
                     bidx_ff   <= '0;
                     climit_ff <= ccount_ff;
                     if (q_item.amount > 10'd1) begin
                        gap_ff <= gsum[24] ? 24'hFFFFFF : gsum[23:0];
                        trig_ff <= !running_ff && (gsum[24] || gsum[23:0] >= min_gap)
                           && ((25'd320 * 25'(q_item.rand_trigger))
                               < (25'd3 * 25'(q_item.amount) * 25'(q_item.amount)));
                     end else begin
                        trig_ff <= 1'b0;
                     end
                  end else begin
                     trig_ff <= 1'b0;
                     if (bidx_ff != 12'hFFF) bidx_ff <= bidx_ff + 12'd1;
                  end
                  state_ff <= S_MUL1;
               end
            end
            S_MUL1: begin
               num_ff <= (37'd10 << 26) + 37'(it_ff.rand_length) *
                         37'(18'd204800 - 18'd160 * 18'(held_ff));
               x_ff   <= crush(it_ff.sample, held_ff);
               state_ff <= S_MUL2;
            end
            S_MUL2: begin
               prod_ff  <= 53'(num_ff) * 53'(spm_q8);
               state_ff <= S_MEM;
            end
            S_MEM: begin
               if (trig_ff) begin
                  clen_ff   <= cl15;
                  ccount_ff <= '0;
                  climit_ff <= (len14 < 14'(cl15)) ? len14 : 14'(cl15);
                  remain_ff <= 17'(cl15) * 17'({1'b0, it_ff.rep} + 4'd1);
                  rindex_ff <= '0;
                  running_ff <= 1'b1;
                  gap_ff    <= '0;
               end
               state_ff <= S_OUT;
            end
            S_OUT: begin
               // Hold here while the previous result still waits.
               if (!rvalid_ff || rsp_ready) begin
                  // Capture then replay, using post-trigger state; an amount of 1 or less passes the sample through.
                  if (held_ff <= 10'd1) begin
                     rsp_ff <= '{sample_out: it_ff.sample, stutter_active: 1'b0};
                  end else begin
                     if (ccount_ff < climit_ff) ccount_ff <= ccount_ff + 14'd1;
                     if (running_ff && remain_ff != 17'd0) begin
                        rindex_ff <= (15'(rindex_ff) + 15'd1 >= clen_ff) ? 14'd0
                                     : rindex_ff + 14'd1;
                        remain_ff <= remain_ff - 17'd1;
                        if (remain_ff == 17'd1) running_ff <= 1'b0;
                        rsp_ff <= '{sample_out: use_mem_ff ? rd_ff : 16'sd0,
                                    stutter_active: 1'b1};
                     end else begin
                        running_ff <= 1'b0;
                        rsp_ff <= '{sample_out: x_ff, stutter_active: 1'b0};
                     end
                  end
                  rvalid_ff <= 1'b1;
                  state_ff  <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   // Store port: write the crushed sample, read the replay position (with
   // same-position forwarding of the sample being captured now).
   always_ff @(posedge clock) begin
      if (state_ff == S_MEM) begin
         if (trig_ff) begin
            rd_ff      <= x_ff;
            use_mem_ff <= (it_ff.len != 13'd0);
         end else begin
            rd_ff      <= (rindex_ff == ccount_ff) ? x_ff : mem[rindex_ff];
            use_mem_ff <= (rindex_ff < ccount_ff) ||
                          (rindex_ff == ccount_ff && ccount_ff < climit_ff);
         end
      end
      if (state_ff == S_OUT && (!rvalid_ff || rsp_ready) && held_ff > 10'd1 &&
          ccount_ff < climit_ff)
         mem[ccount_ff] <= x_ff;
   end
endmodule

@@ design/stutter_bitcrush_glitch_top.sv @@
// Top level of the stutter-repeat and bitcrusher glitch block.
//  channel | direction | handshake            | payload
//  req     | in        | req_valid/req_ready  | req_data (req_type)
//  rsp     | out       | rsp_valid/rsp_ready  | rsp_data (rsp_type)
//  csr     | in        | csr_we               | csr_index, csr_wdata
// Each request passes five steps in the back end sequencer (latch, multiply for
// the capture length, multiply by the sample rate, store access, result);
// the result step holds while the previous result still waits for rsp_ready.
// Reset is synchronous, active high; it clears the state machine, counters and queue pointers and loads
// the default register values. The capture store is not cleared.
// A two-entry queue decouples the request side from the result register,
// so requests are taken while a result waits for rsp_ready, as long as the queue has room.
module stutter_bitcrush_glitch_top import sbg_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output rsp_type     rsp_data,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [23:0] csr_wdata
);
   logic [15:0] spm_ff;
   logic [23:0] gap_ff;
   logic [14:0] cap_ff;
   logic        q_valid, q_ready;
   item_type    q_item;

   // Hold the configuration registers; the user must write them only while idle, the block itself does not enforce it.
   always_ff @(posedge clock) begin
      if (reset) begin
         spm_ff <= 16'd12288;
         gap_ff <= 24'd7200;
         cap_ff <= 15'd14400;
      end else if (csr_we) begin
         case (csr_index)
            CSR_SPM:     spm_ff <= csr_wdata[15:0];
            CSR_MIN_GAP: gap_ff <= csr_wdata;
            CSR_MAX_CAP: cap_ff <= csr_wdata[14:0];
            default:     ;
         endcase
      end
   end

   sbg_front u_front (
      .clock, .reset, .req_valid, .req_ready, .req_data,
      .q_valid, .q_ready, .q_item
   );

   sbg_back u_back (
      .clock, .reset, .q_valid, .q_ready, .q_item,
      .spm_q8(spm_ff), .min_gap(gap_ff), .max_cap(cap_ff),
      .rsp_valid, .rsp_ready, .rsp_data
   );

   // A result is never overwritten while still waiting.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result dropped");
   // When the queue is full (req_ready low), it must also show a valid entry.
   a_q_full: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> q_valid)
      else $error("queue state broken");
endmodule
